// ===== design/gdad_pkg.sv =====
// Package: shared widths, month table and month-length function for the date adder.
`timescale 1ns / 1ps
`default_nettype none
package gdad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ADD_W   = 16;
    // add count + start day + up to twelve full months
    localparam int REM_W   = 17;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

    // Gregorian cycle and its century points
    localparam logic [YEAR_W-1:0] CYCLE_LEN  = 14'd400;
    localparam logic [YEAR_W-1:0] CYCLE_LAST = 14'd399;
    localparam logic [YEAR_W-1:0] CENT_1     = 14'd100;
    localparam logic [YEAR_W-1:0] CENT_2     = 14'd200;
    localparam logic [YEAR_W-1:0] CENT_3     = 14'd300;

    typedef logic [DAY_W-1:0] t_mlen;

    localparam t_mlen MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Length of month m; months outside 1..12 have length zero.
    function automatic t_mlen month_days(input logic [MONTH_W-1:0] m, input logic leap);
        logic [MONTH_W-1:0] idx;
        t_mlen              len;
        idx = m - MON_JAN;
        if (m < MON_JAN || m > MON_DEC) begin
            len = '0;
        end else if (m == MON_FEB) begin
            len = leap ? FEB_LEAP_LEN : MONTH_LEN[idx];
        end else begin
            len = MONTH_LEN[idx];
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== design/gregorian_date_add_days_core.sv =====
// Top level: Gregorian date plus day count, computed by a sequenced add/subtract unit.
//
// Input channel i_in_valid / o_in_ready carries a start date and a day count;
// output channel o_out_valid / i_out_ready carries the resulting date. One
// transfer on each side moves one item.
// An item is handled alone: after acceptance the block reduces the start year
// modulo 400 (one compare-subtract per cycle), sums the lengths of the months
// before the start month (one month per cycle), then walks forward from
// January one month per cycle through the shared add/subtract and compare
// unit until the remainder fits the month. The next item is not taken until
// the current one has left the done state, so the length of the walk sets
// the throughput.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished item waits in the done state
// until the output register frees up.
// Synchronous active-low reset returns the sequencer to idle and drops
// o_out_valid; result payload registers are not reset.
// The leap rule follows the year's residue modulo 400, which is tracked as
// the year advances and cleared when the 14-bit year wraps to zero.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_add_days_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [gdad_pkg::DAY_W-1:0]    i_start_day,
    input  wire logic [gdad_pkg::MONTH_W-1:0]  i_start_month,
    input  wire logic [gdad_pkg::YEAR_W-1:0]   i_start_year,
    input  wire logic [gdad_pkg::ADD_W-1:0]    i_days_to_add,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [gdad_pkg::DAY_W-1:0]         o_result_day,
    output logic [gdad_pkg::MONTH_W-1:0]       o_result_month,
    output logic [gdad_pkg::YEAR_W-1:0]        o_result_year
);
    import gdad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [2:0] MOD_TOP = 3'd5;  // 400 << 5 is the largest power-of-two multiple of 400 below 2^14

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_k, n_k;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [MONTH_W-1:0] r_mon, n_mon;
    logic [MONTH_W-1:0] r_smon, n_smon;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [YEAR_W-1:0]  r_ymod, n_ymod;
    logic               r_out_valid, n_out_valid;
    logic [DAY_W-1:0]   r_res_day, n_res_day;
    logic [MONTH_W-1:0] r_res_mon, n_res_mon;
    logic [YEAR_W-1:0]  r_res_year, n_res_year;

    logic               leap;
    t_mlen              len;
    logic               op_sub;
    logic [REM_W-1:0]   alu_out;
    logic               rem_gt;
    logic [YEAR_W:0]    mod_cand;
    logic               in_xfer;
    logic               out_free;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign leap = (r_ymod[1:0] == 2'b00) && (r_ymod != CENT_1) && (r_ymod != CENT_2)
                  && (r_ymod != CENT_3);
    assign len  = month_days(r_mon, leap);

    // shared unit: add month length while summing, subtract while walking
    assign op_sub  = (r_state == ST_WALK);
    assign alu_out = op_sub ? (r_rem - {{(REM_W-DAY_W){1'b0}}, len})
                            : (r_rem + {{(REM_W-DAY_W){1'b0}}, len});
    assign rem_gt  = (r_rem > {{(REM_W-DAY_W){1'b0}}, len});

    assign mod_cand = {1'b0, CYCLE_LEN} << r_k;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rem       = r_rem;
        n_mon       = r_mon;
        n_smon      = r_smon;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res_day   = r_res_day;
        n_res_mon   = r_res_mon;
        n_res_year  = r_res_year;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_rem   = {1'b0, i_days_to_add} + {{(REM_W-DAY_W){1'b0}}, i_start_day};
                    n_smon  = i_start_month;
                    n_year  = i_start_year;
                    n_ymod  = i_start_year;
                    n_k     = MOD_TOP;
                    n_mon   = MON_JAN;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if ({1'b0, r_ymod} >= mod_cand) begin
                    n_ymod = r_ymod - mod_cand[YEAR_W-1:0];
                end
                if (r_k == 3'd0) begin
                    n_state = ST_ACC;
                end else begin
                    n_k = r_k - 3'd1;
                end
            end
            ST_ACC: begin
                if (r_mon < r_smon) begin
                    n_rem = alu_out;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_mon   = MON_JAN;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rem_gt) begin
                    n_rem = alu_out;
                    if (r_mon == MON_DEC) begin
                        n_mon  = MON_JAN;
                        n_year = r_year + 14'd1;
                        // year wrap to zero restarts the 400-year cycle
                        if (r_year == {YEAR_W{1'b1}} || r_ymod == CYCLE_LAST) begin
                            n_ymod = '0;
                        end else begin
                            n_ymod = r_ymod + 14'd1;
                        end
                    end else begin
                        n_mon = r_mon + 4'd1;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res_day   = r_rem[DAY_W-1:0];
                    n_res_mon   = r_mon;
                    n_res_year  = r_year;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_rem      <= n_rem;
        r_mon      <= n_mon;
        r_smon     <= n_smon;
        r_year     <= n_year;
        r_ymod     <= n_ymod;
        r_res_day  <= n_res_day;
        r_res_mon  <= n_res_mon;
        r_res_year <= n_res_year;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_day   = r_res_day;
    assign o_result_month = r_res_mon;
    assign o_result_year  = r_res_year;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_MOD))
        else $error("accepted item did not start year reduction");

    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_mon >= MON_JAN && r_mon <= MON_DEC))
        else $error("walk month out of range");

    a_walk_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_ymod < CYCLE_LEN))
        else $error("year residue not reduced below 400");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished item not moved to output register");

endmodule
`default_nettype wire
